FILE: rtl/bf3_pkg.sv
// Shared constants and types of the 3x3 RGB box filter.
package bf3_pkg;

	// Port widths fixed by the interface
	localparam int FS_W     = 10;
	localparam int FS_RESET = 512;
	localparam int PORT_W   = 16;

	// Queue depths between and after the two halves
	localparam int MQ_DEPTH = 4;
	localparam int OQ_DEPTH = 8;
	localparam int OQ_LVL_W = $clog2(OQ_DEPTH + 1);

	// Growth of a nine-term sum over one channel
	localparam int SUM_GROW = 4;

	// Request kinds on cmd
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// Odd part of the neighbour count: 1, 3 or 9
	typedef enum logic [1:0] {
		DIV_1 = 2'd0,
		DIV_3 = 2'd1,
		DIV_9 = 2'd2
	} div_t;

	// Per-request control handed from the front to the back
	typedef struct packed {
		logic       emit;       // request produces a result
		logic       right_end;  // result taken from the window before the shift
		logic       last;       // final result of the frame
		logic [2:0] rmask;      // window rows inside the frame (bit 0 = row above)
		logic [2:0] cmask;      // window columns inside the frame (bit 0 = oldest)
		logic [1:0] shift;      // power-of-two part of the neighbour count
		div_t       div;        // odd part of the neighbour count
	} ctl_t;

endpackage

FILE: rtl/box_filter_3x3_rgb.sv
// Top level of the 3x3 mean filter over a square RGB frame.
//
// Pixels enter in raster order through push/full, one request per clock while
// full is low; cmd selects a pixel or a flush tick. After the last pixel of a
// frame of size N the source sends N+1 flush ticks; requests of the wrong kind
// are taken and ignored. Results leave through empty/pop in frame order, the
// final one flagged by frame_last. A result appears N+1 requests after its
// pixel. With both queues idle it passes through the request queue, line store
// read, window, two adder levels, reciprocal multiply and correction into the
// result queue before pop can take it. Sustained rate is one request per clock
// while results are popped, set by the line store, which takes one read and one
// write per clock. Reset empties both queues, returns to the frame origin and
// sets the frame size to 512 (clamped to MAX_SIZE); line stores are not cleared,
// since every column is rewritten before it enters a result. Writing cfg_wdata
// restarts the frame. When pop stays low, up to eight results wait; the back
// half then stops drawing from its four-entry request queue and full rises once
// it fills.
module box_filter_3x3_rgb #(
	parameter int MAX_SIZE     = 512,
	parameter int CHANNEL_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bf3_pkg::FS_W-1:0]   cfg_wdata,
	input  logic                       push,
	output logic                       full,
	input  logic                       cmd,
	input  logic [bf3_pkg::PORT_W-1:0] in_red,
	input  logic [bf3_pkg::PORT_W-1:0] in_green,
	input  logic [bf3_pkg::PORT_W-1:0] in_blue,
	output logic                       empty,
	input  logic                       pop,
	output logic [bf3_pkg::PORT_W-1:0] out_red,
	output logic [bf3_pkg::PORT_W-1:0] out_green,
	output logic [bf3_pkg::PORT_W-1:0] out_blue,
	output logic                       frame_last
);

	localparam int CB     = CHANNEL_BITS;
	localparam int PIX_W  = 3 * CB;
	localparam int ADDR_W = $clog2(MAX_SIZE);
	localparam int CTL_W  = $bits(bf3_pkg::ctl_t);
	localparam int MQ_W   = CTL_W + ADDR_W + PIX_W;
	localparam int OQ_W   = PIX_W + 1;

	logic                         f_push, b_pop, mq_empty, o_push;
	bf3_pkg::ctl_t                f_ctl, b_ctl;
	logic [ADDR_W-1:0]            f_addr, b_addr;
	logic [PIX_W-1:0]             f_pix, b_pix;
	logic [MQ_W-1:0]              mq_wdata, mq_rdata;
	logic [OQ_W-1:0]              o_data, oq_rdata;
	logic [bf3_pkg::OQ_LVL_W-1:0] oq_level;

	// Classify requests and track frame position
	bf3_front #(
		.MAX_SIZE     (MAX_SIZE),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.cmd       (cmd),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.q_full    (full),
		.q_push    (f_push),
		.q_ctl     (f_ctl),
		.q_addr    (f_addr),
		.q_pix     (f_pix)
	);

	// Decouple front and back
	assign mq_wdata = {f_ctl, f_addr, f_pix};
	assign b_ctl    = bf3_pkg::ctl_t'(mq_rdata[MQ_W-1 -: CTL_W]);
	assign b_addr   = mq_rdata[PIX_W +: ADDR_W];
	assign b_pix    = mq_rdata[PIX_W-1:0];

	bf3_fifo #(
		.WIDTH (MQ_W),
		.DEPTH (bf3_pkg::MQ_DEPTH)
	) u_req_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_push),
		.wr_data (mq_wdata),
		.full    (full),
		.rd_en   (b_pop),
		.rd_data (mq_rdata),
		.empty   (mq_empty),
		.level   ()
	);

	// Window, sums and division
	bf3_back #(
		.MAX_SIZE     (MAX_SIZE),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (mq_empty),
		.q_ctl    (b_ctl),
		.q_addr   (b_addr),
		.q_pix    (b_pix),
		.q_pop    (b_pop),
		.oq_level (oq_level),
		.o_push   (o_push),
		.o_data   (o_data)
	);

	// Hold results until the receiver takes them
	bf3_fifo #(
		.WIDTH (OQ_W),
		.DEPTH (bf3_pkg::OQ_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (o_push),
		.wr_data (o_data),
		.full    (),
		.rd_en   (pop),
		.rd_data (oq_rdata),
		.empty   (empty),
		.level   (oq_level)
	);

	// Widen channels onto the result ports
	assign out_red    = bf3_pkg::PORT_W'(oq_rdata[CB-1:0]);
	assign out_green  = bf3_pkg::PORT_W'(oq_rdata[2*CB-1:CB]);
	assign out_blue   = bf3_pkg::PORT_W'(oq_rdata[3*CB-1:2*CB]);
	assign frame_last = oq_rdata[PIX_W];

endmodule

FILE: rtl/bf3_fifo.sv
// Small register-based FIFO used between and after the filter halves.
module bf3_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	output logic                       full,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVL_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [LVL_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	// Qualify both sides against occupancy
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign full    = (cnt_q == LVL_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign level   = cnt_q;
	assign rd_data = slot_q[rd_ptr_q];

	// Store incoming request
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + LVL_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - LVL_W'(1);
			end
		end
	end

endmodule

FILE: rtl/bf3_front.sv
// Front half: frame position tracking, request classification and window masks.
module bf3_front #(
	parameter int MAX_SIZE     = 512,
	parameter int CHANNEL_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bf3_pkg::FS_W-1:0]      cfg_wdata,
	input  logic                          push,
	input  logic                          cmd,
	input  logic [bf3_pkg::PORT_W-1:0]    in_red,
	input  logic [bf3_pkg::PORT_W-1:0]    in_green,
	input  logic [bf3_pkg::PORT_W-1:0]    in_blue,
	input  logic                          q_full,
	output logic                          q_push,
	output bf3_pkg::ctl_t                 q_ctl,
	output logic [$clog2(MAX_SIZE)-1:0]   q_addr,
	output logic [3*CHANNEL_BITS-1:0]     q_pix
);

	localparam int CB     = CHANNEL_BITS;
	localparam int CNT_W  = $clog2(MAX_SIZE + 2);
	localparam int ADDR_W = $clog2(MAX_SIZE);
	localparam int RST_N  = (bf3_pkg::FS_RESET > MAX_SIZE) ? MAX_SIZE : bf3_pkg::FS_RESET;

	logic [CNT_W-1:0] n_q, ir_q, ic_q, or_q, oc_q;
	logic [CNT_W-1:0] n_new, n_p1, ic_p1, or_p1, oc_p1;
	logic             flushing, is_flush, match, emit, last, right_end;
	logic [2:0]       rmask, cmask;
	logic [1:0]       nrows, ncols, n2, n3;
	bf3_pkg::div_t    div;

	// Clamp the written frame size into 1..MAX_SIZE
	always_comb begin
		if (cfg_wdata == '0) begin
			n_new = CNT_W'(1);
		end else if (32'(cfg_wdata) > 32'(MAX_SIZE)) begin
			n_new = CNT_W'(MAX_SIZE);
		end else begin
			n_new = CNT_W'(cfg_wdata);
		end
	end

	// Classify the request at the current position
	always_comb begin
		n_p1      = n_q + CNT_W'(1);
		ic_p1     = ic_q + CNT_W'(1);
		or_p1     = or_q + CNT_W'(1);
		oc_p1     = oc_q + CNT_W'(1);
		flushing  = (ir_q >= n_q);
		is_flush  = (cmd == bf3_pkg::CMD_FLUSH);
		match     = (is_flush == flushing);
		emit      = (ir_q >= CNT_W'(2)) || ((ir_q == CNT_W'(1)) && (ic_q != '0));
		last      = (ir_q == n_p1) && (ic_q == '0);
		right_end = (ic_q == '0);
	end

	// Build row and column masks and the neighbour count
	always_comb begin
		rmask = {(or_p1 < n_q), 1'b1, (or_q != '0)};
		if (right_end) begin
			cmask = {1'b1, (oc_q >= CNT_W'(1)), (oc_q >= CNT_W'(2))};
		end else begin
			cmask = {(oc_p1 < n_q), 1'b1, (oc_q != '0)};
		end
		nrows = 2'(rmask[0]) + 2'(rmask[1]) + 2'(rmask[2]);
		ncols = 2'(cmask[0]) + 2'(cmask[1]) + 2'(cmask[2]);
		n2    = 2'(nrows == 2'd2) + 2'(ncols == 2'd2);
		n3    = 2'(nrows == 2'd3) + 2'(ncols == 2'd3);
		unique case (n3)
			2'd0:    div = bf3_pkg::DIV_1;
			2'd1:    div = bf3_pkg::DIV_3;
			default: div = bf3_pkg::DIV_9;
		endcase
	end

	// Drive the request toward the back half
	always_comb begin
		q_push          = push && !q_full && match;
		q_ctl.emit      = emit;
		q_ctl.right_end = right_end;
		q_ctl.last      = last;
		q_ctl.rmask     = rmask;
		q_ctl.cmask     = cmask;
		q_ctl.shift     = n2;
		q_ctl.div       = div;
		q_addr          = ic_q[ADDR_W-1:0];
		if (is_flush) begin
			q_pix = '0;
		end else begin
			q_pix = {in_blue[CB-1:0], in_green[CB-1:0], in_red[CB-1:0]};
		end
	end

	// Advance input and output positions; restart on frame end or size write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q  <= CNT_W'(RST_N);
			ir_q <= '0;
			ic_q <= '0;
			or_q <= '0;
			oc_q <= '0;
		end else if (cfg_we) begin
			n_q  <= n_new;
			ir_q <= '0;
			ic_q <= '0;
			or_q <= '0;
			oc_q <= '0;
		end else if (q_push) begin
			if (last) begin
				ir_q <= '0;
				ic_q <= '0;
				or_q <= '0;
				oc_q <= '0;
			end else begin
				if (ic_p1 >= n_q) begin
					ic_q <= '0;
					ir_q <= ir_q + CNT_W'(1);
				end else begin
					ic_q <= ic_p1;
				end
				if (emit) begin
					if (oc_p1 >= n_q) begin
						oc_q <= '0;
						or_q <= or_p1;
					end else begin
						oc_q <= oc_p1;
					end
				end
			end
		end
	end

endmodule

FILE: rtl/bf3_back.sv
// Back half: line stores, 3x3 window, neighbour sums and constant division.
module bf3_back #(
	parameter int MAX_SIZE     = 512,
	parameter int CHANNEL_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  bf3_pkg::ctl_t                  q_ctl,
	input  logic [$clog2(MAX_SIZE)-1:0]    q_addr,
	input  logic [3*CHANNEL_BITS-1:0]      q_pix,
	output logic                           q_pop,
	input  logic [bf3_pkg::OQ_LVL_W-1:0]   oq_level,
	output logic                           o_push,
	output logic [3*CHANNEL_BITS:0]        o_data
);

	localparam int CB     = CHANNEL_BITS;
	localparam int PIX_W  = 3 * CB;
	localparam int ADDR_W = $clog2(MAX_SIZE);
	localparam int W      = CB + bf3_pkg::SUM_GROW;
	localparam int RS_W   = CB + 2;
	localparam int OCC_W  = bf3_pkg::OQ_LVL_W + 1;
	localparam logic [W-1:0] M3 = W'((2 ** W) / 3);
	localparam logic [W-1:0] M9 = W'((2 ** W) / 9);

	// Line store: {row two back, row one back} per column
	logic [2*PIX_W-1:0]  mem [MAX_SIZE];
	logic [2*PIX_W-1:0]  rd_q, fwd_word_q, line_word, wr_word;
	logic                fwd_q, wr_en;
	logic [OCC_W-1:0]    occ;

	logic                v_s1;
	bf3_pkg::ctl_t       ctl_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic [PIX_W-1:0]    pix_s1;

	logic [PIX_W-1:0]    win_q  [3][3];
	logic [PIX_W-1:0]    nwin   [3][3];
	logic [PIX_W-1:0]    snap   [3][3];

	logic                v_s2, last_s2;
	logic [1:0]          sh_s2;
	bf3_pkg::div_t       div_s2;
	logic [PIX_W-1:0]    snap_s2 [3][3];

	logic                v_s3, last_s3;
	logic [1:0]          sh_s3;
	bf3_pkg::div_t       div_s3;
	logic [RS_W-1:0]     rs_s3 [3][3];

	logic                v_s4, last_s4;
	bf3_pkg::div_t       div_s4;
	logic [W-1:0]        x_s4 [3];

	logic                v_s5, last_s5;
	bf3_pkg::div_t       div_s5;
	logic [W-1:0]        x_s5  [3];
	logic [W-1:0]        q0_s5 [3];

	logic [RS_W-1:0]     rs   [3][3];
	logic [W-1:0]        tot  [3];
	logic [W-1:0]        m4;
	logic [2*W-1:0]      prod [3];
	logic [W-1:0]        q0   [3];
	logic [W-1:0]        qd   [3];
	logic [W-1:0]        rem  [3];
	logic [W-1:0]        quo  [3];

	// Issue a request only when the result queue can absorb everything in flight
	always_comb begin
		occ   = OCC_W'(oq_level) + OCC_W'(v_s1) + OCC_W'(v_s2) + OCC_W'(v_s3)
		      + OCC_W'(v_s4) + OCC_W'(v_s5);
		q_pop = !q_empty && (occ < OCC_W'(bf3_pkg::OQ_DEPTH));
	end

	// Read at issue, write back in the following cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s1] <= wr_word;
		end
		if (q_pop) begin
			rd_q       <= mem[q_addr];
			fwd_q      <= wr_en && (addr_s1 == q_addr);
			fwd_word_q <= wr_word;
		end
	end

	// Take the line store word, forwarding a write to the same column
	always_comb begin
		line_word = fwd_q ? fwd_word_q : rd_q;
		wr_en     = v_s1;
		wr_word   = {line_word[PIX_W-1:0], pix_s1};
	end

	// Shift the window and pick the result view
	always_comb begin
		for (int d = 0; d < 3; d++) begin
			nwin[d][0] = win_q[d][1];
			nwin[d][1] = win_q[d][2];
		end
		nwin[0][2] = line_word[2*PIX_W-1:PIX_W];
		nwin[1][2] = line_word[PIX_W-1:0];
		nwin[2][2] = pix_s1;
		for (int d = 0; d < 3; d++) begin
			for (int e = 0; e < 3; e++) begin
				if (ctl_s1.rmask[d] && ctl_s1.cmask[e]) begin
					snap[d][e] = ctl_s1.right_end ? win_q[d][e] : nwin[d][e];
				end else begin
					snap[d][e] = '0;
				end
			end
		end
	end

	// Hold payload of each stage
	always_ff @(posedge clk) begin
		if (q_pop) begin
			ctl_s1  <= q_ctl;
			addr_s1 <= q_addr;
			pix_s1  <= q_pix;
		end
		if (v_s1) begin
			win_q   <= nwin;
			snap_s2 <= snap;
			last_s2 <= ctl_s1.last;
			sh_s2   <= ctl_s1.shift;
			div_s2  <= ctl_s1.div;
		end
		rs_s3   <= rs;
		last_s3 <= last_s2;
		sh_s3   <= sh_s2;
		div_s3  <= div_s2;
		x_s4    <= tot;
		last_s4 <= last_s3;
		div_s4  <= div_s3;
		x_s5    <= x_s4;
		q0_s5   <= q0;
		last_s5 <= last_s4;
		div_s5  <= div_s4;
	end

	// Advance stage valids; drop requests that carry no result after the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= q_pop;
			v_s2 <= v_s1 && ctl_s1.emit;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Sum each window row per channel
	always_comb begin
		for (int d = 0; d < 3; d++) begin
			for (int ch = 0; ch < 3; ch++) begin
				rs[d][ch] = RS_W'(snap_s2[d][0][ch*CB +: CB])
				          + RS_W'(snap_s2[d][1][ch*CB +: CB])
				          + RS_W'(snap_s2[d][2][ch*CB +: CB]);
			end
		end
	end

	// Add the rows and strip the power-of-two part of the count
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			tot[ch] = (W'(rs_s3[0][ch]) + W'(rs_s3[1][ch]) + W'(rs_s3[2][ch])) >> sh_s3;
		end
	end

	// Estimate the quotient by 3 or 9 with a reciprocal multiply
	always_comb begin
		unique case (div_s4)
			bf3_pkg::DIV_3: m4 = M3;
			bf3_pkg::DIV_9: m4 = M9;
			default:        m4 = '0;
		endcase
		for (int ch = 0; ch < 3; ch++) begin
			prod[ch] = (2*W)'(x_s4[ch]) * (2*W)'(m4);
			q0[ch]   = (div_s4 == bf3_pkg::DIV_1) ? x_s4[ch] : prod[ch][2*W-1:W];
		end
	end

	// Correct the estimate by at most one
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			unique case (div_s5)
				bf3_pkg::DIV_3: begin
					qd[ch]  = q0_s5[ch] + (q0_s5[ch] << 1);
					rem[ch] = x_s5[ch] - qd[ch];
					quo[ch] = (rem[ch] >= W'(3)) ? q0_s5[ch] + W'(1) : q0_s5[ch];
				end
				bf3_pkg::DIV_9: begin
					qd[ch]  = q0_s5[ch] + (q0_s5[ch] << 3);
					rem[ch] = x_s5[ch] - qd[ch];
					quo[ch] = (rem[ch] >= W'(9)) ? q0_s5[ch] + W'(1) : q0_s5[ch];
				end
				default: begin
					qd[ch]  = q0_s5[ch];
					rem[ch] = '0;
					quo[ch] = q0_s5[ch];
				end
			endcase
		end
		o_push = v_s5;
		o_data = {last_s5, quo[2][CB-1:0], quo[1][CB-1:0], quo[0][CB-1:0]};
	end

endmodule
